### sv/traffic_burst_tracker_macros.svh
// Assertion macros for the traffic burst tracker.
// Used by the top level; the checks compile away when SYNTHESIS is defined.
`ifndef TRAFFIC_BURST_TRACKER_MACROS_SVH
`define TRAFFIC_BURST_TRACKER_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked outside reset.
`define TBT_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tbt assertion failed: same-cycle implication");
// Next-cycle implication, checked outside reset.
`define TBT_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tbt assertion failed: next-cycle implication");
// Next-cycle implication that is also checked while reset is held.
`define TBT_ASSERT_RST(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("tbt assertion failed: reset behavior");
`else
`define TBT_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define TBT_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`define TBT_ASSERT_RST(lbl, clk, ante, cons)
`endif
`endif

### sv/tbt_pkg.sv
// Shared widths, defaults and the burst summary type of the traffic burst tracker.
// Used by every module of the block; depends on nothing.
package tbt_pkg;

  localparam int TIME_W  = 63;
  localparam int MD_W    = 2;
  localparam int SIZE_W  = 33;
  localparam int DUR_W   = 40;
  localparam int SRC_W   = 8;
  localparam int CNT_W   = 32;
  localparam int BYTES_W = 48;
  localparam int BUSY_W  = 64;
  localparam int ACT_W   = 33;

  localparam int STRAGGLER_SLOTS_DEF = 4;

  // Depth of the summary queue between the front and back parts.
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);

  localparam logic [MD_W-1:0] MD_START = 2'b01;

  // Summary of one closed burst, handed from the front to the back.
  typedef struct packed {
    logic [TIME_W-1:0]  burst_start;
    logic [TIME_W-1:0]  burst_end;
    logic [CNT_W-1:0]   message_count;
    logic [CNT_W-1:0]   max_overlap;
    logic [BYTES_W-1:0] burst_bytes;
    logic [TIME_W-1:0]  span;
    logic               underflow;
  } snap_t;

endpackage

### sv/tbt_front.sv
// Front part: accepts events, tracks the active count and burst statistics,
// keeps the straggler ring and pushes a burst summary when a burst closes. Uses tbt_pkg.
module tbt_front #(
  parameter int STRAGGLER_SLOTS = tbt_pkg::STRAGGLER_SLOTS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_push,
  output logic                        in_full,
  input  logic [tbt_pkg::TIME_W-1:0]  in_event_time,
  input  logic signed [tbt_pkg::MD_W-1:0]   in_message_delta,
  input  logic signed [tbt_pkg::SIZE_W-1:0] in_size_delta,
  input  logic [tbt_pkg::DUR_W-1:0]   in_duration_ns,
  input  logic [tbt_pkg::SRC_W-1:0]   in_source_slice,
  input  logic                        q_full,
  output logic                        q_push,
  output tbt_pkg::snap_t              q_snap,
  output logic [STRAGGLER_SLOTS-1:0]  q_ring_valid,
  output logic [tbt_pkg::DUR_W-1:0]   q_ring_dur [STRAGGLER_SLOTS],
  output logic [tbt_pkg::TIME_W-1:0]  q_ring_end [STRAGGLER_SLOTS],
  output logic [tbt_pkg::SRC_W-1:0]   q_ring_src [STRAGGLER_SLOTS]
);

  localparam int PTR_W = (STRAGGLER_SLOTS > 1) ? $clog2(STRAGGLER_SLOTS) : 1;

  logic [tbt_pkg::ACT_W-1:0]   active_r, active_nxt;
  logic [tbt_pkg::TIME_W-1:0]  start_r, start_nxt;
  logic [tbt_pkg::CNT_W-1:0]   started_r, started_nxt;
  logic [tbt_pkg::CNT_W-1:0]   peak_r, peak_nxt;
  logic [tbt_pkg::BYTES_W-1:0] bytes_r, bytes_nxt;
  logic                        underflow_r, underflow_nxt;
  logic [PTR_W-1:0]            ptr_r, ptr_nxt;
  logic [STRAGGLER_SLOTS-1:0]  valid_r;
  logic [tbt_pkg::DUR_W-1:0]   dur_r [STRAGGLER_SLOTS];
  logic [tbt_pkg::TIME_W-1:0]  end_r [STRAGGLER_SLOTS];
  logic [tbt_pkg::SRC_W-1:0]   src_r [STRAGGLER_SLOTS];

  logic                        accept;
  logic                        is_start;
  logic                        close;
  logic [tbt_pkg::ACT_W:0]     act_sum;
  logic [tbt_pkg::BYTES_W+1:0] byte_sum;
  logic [tbt_pkg::TIME_W-1:0]  span;

  assign in_full  = q_full;
  assign accept   = in_push && !q_full;
  assign is_start = (in_message_delta == tbt_pkg::MD_START);

  always_comb begin
    start_nxt = (active_r == '0) ? in_event_time : start_r;

    // One extra bit shows when the count leaves the 33-bit signed range.
    act_sum = {active_r[tbt_pkg::ACT_W-1], active_r}
            + {{(tbt_pkg::ACT_W-1){in_message_delta[1]}}, in_message_delta};
    if (act_sum[tbt_pkg::ACT_W] != act_sum[tbt_pkg::ACT_W-1]) begin
      active_nxt = act_sum[tbt_pkg::ACT_W] ? {1'b1, {(tbt_pkg::ACT_W-1){1'b0}}}
                                           : {1'b0, {(tbt_pkg::ACT_W-1){1'b1}}};
    end else begin
      active_nxt = act_sum[tbt_pkg::ACT_W-1:0];
    end
    underflow_nxt = underflow_r || active_nxt[tbt_pkg::ACT_W-1];
    close = (active_nxt == '0);

    started_nxt = started_r;
    bytes_nxt   = bytes_r;
    byte_sum    = {2'b00, bytes_r}
                + {{(tbt_pkg::BYTES_W+2-tbt_pkg::SIZE_W){in_size_delta[tbt_pkg::SIZE_W-1]}},
                   in_size_delta};
    if (is_start) begin
      if (started_r != '1) begin
        started_nxt = started_r + 1'b1;
      end
      if (byte_sum[tbt_pkg::BYTES_W+1]) begin
        bytes_nxt = '0;
      end else if (byte_sum[tbt_pkg::BYTES_W]) begin
        bytes_nxt = '1;
      end else begin
        bytes_nxt = byte_sum[tbt_pkg::BYTES_W-1:0];
      end
    end

    // A positive count always fits in 32 bits after saturation.
    peak_nxt = peak_r;
    if (!active_nxt[tbt_pkg::ACT_W-1] && !close &&
        (active_nxt[tbt_pkg::CNT_W-1:0] > peak_r)) begin
      peak_nxt = active_nxt[tbt_pkg::CNT_W-1:0];
    end

    ptr_nxt = ptr_r;
    if (!is_start) begin
      ptr_nxt = (ptr_r == PTR_W'(STRAGGLER_SLOTS - 1)) ? '0 : ptr_r + 1'b1;
    end

    span = (in_event_time >= start_nxt) ? in_event_time - start_nxt : '0;
  end

  // The summary sees the ring with the current end event already written.
  always_comb begin
    for (int k = 0; k < STRAGGLER_SLOTS; k++) begin
      if (!is_start && ptr_r == PTR_W'(k)) begin
        q_ring_valid[k] = 1'b1;
        q_ring_dur[k]   = in_duration_ns;
        q_ring_end[k]   = in_event_time;
        q_ring_src[k]   = in_source_slice;
      end else begin
        q_ring_valid[k] = valid_r[k];
        q_ring_dur[k]   = dur_r[k];
        q_ring_end[k]   = end_r[k];
        q_ring_src[k]   = src_r[k];
      end
    end
  end

  assign q_push = accept && close;

  always_comb begin
    q_snap.burst_start   = start_nxt;
    q_snap.burst_end     = in_event_time;
    q_snap.message_count = started_nxt;
    q_snap.max_overlap   = peak_nxt;
    q_snap.burst_bytes   = bytes_nxt;
    q_snap.span          = span;
    q_snap.underflow     = underflow_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= '0;
      start_r     <= '0;
      started_r   <= '0;
      peak_r      <= '0;
      bytes_r     <= '0;
      underflow_r <= 1'b0;
      ptr_r       <= '0;
      valid_r     <= '0;
    end else if (accept) begin
      start_r <= start_nxt;
      if (close) begin
        active_r    <= '0;
        started_r   <= '0;
        peak_r      <= '0;
        bytes_r     <= '0;
        underflow_r <= 1'b0;
        ptr_r       <= '0;
        valid_r     <= '0;
      end else begin
        active_r    <= active_nxt;
        started_r   <= started_nxt;
        peak_r      <= peak_nxt;
        bytes_r     <= bytes_nxt;
        underflow_r <= underflow_nxt;
        ptr_r       <= ptr_nxt;
        valid_r     <= q_ring_valid;
      end
    end
  end

  // Ring contents need no reset: a slot is only read while its valid bit is set.
  always_ff @(posedge clk) begin
    if (accept) begin
      for (int k = 0; k < STRAGGLER_SLOTS; k++) begin
        dur_r[k] <= q_ring_dur[k];
        end_r[k] <= q_ring_end[k];
        src_r[k] <= q_ring_src[k];
      end
    end
  end

endmodule

### sv/tbt_queue.sv
// Short queue of closed-burst summaries with their straggler ring copies.
// Sits between tbt_front and tbt_back. Uses tbt_pkg.
module tbt_queue #(
  parameter int STRAGGLER_SLOTS = tbt_pkg::STRAGGLER_SLOTS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        push,
  output logic                        full,
  input  tbt_pkg::snap_t              wr_snap,
  input  logic [STRAGGLER_SLOTS-1:0]  wr_valid,
  input  logic [tbt_pkg::DUR_W-1:0]   wr_dur [STRAGGLER_SLOTS],
  input  logic [tbt_pkg::TIME_W-1:0]  wr_end [STRAGGLER_SLOTS],
  input  logic [tbt_pkg::SRC_W-1:0]   wr_src [STRAGGLER_SLOTS],
  input  logic                        deq,
  output logic                        head_ok,
  output tbt_pkg::snap_t              head_snap,
  output logic [STRAGGLER_SLOTS-1:0]  head_valid,
  output logic [tbt_pkg::DUR_W-1:0]   head_dur [STRAGGLER_SLOTS],
  output logic [tbt_pkg::TIME_W-1:0]  head_end [STRAGGLER_SLOTS],
  output logic [tbt_pkg::SRC_W-1:0]   head_src [STRAGGLER_SLOTS]
);

  tbt_pkg::snap_t               snap_q  [tbt_pkg::QDEPTH];
  logic [STRAGGLER_SLOTS-1:0]   valid_q [tbt_pkg::QDEPTH];
  logic [tbt_pkg::DUR_W-1:0]    dur_q   [tbt_pkg::QDEPTH][STRAGGLER_SLOTS];
  logic [tbt_pkg::TIME_W-1:0]   end_q   [tbt_pkg::QDEPTH][STRAGGLER_SLOTS];
  logic [tbt_pkg::SRC_W-1:0]    src_q   [tbt_pkg::QDEPTH][STRAGGLER_SLOTS];

  logic [tbt_pkg::QPTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [tbt_pkg::QPTR_W:0]     count_r;
  logic                         do_push, do_pop;

  assign full    = (count_r == (tbt_pkg::QPTR_W+1)'(tbt_pkg::QDEPTH));
  assign head_ok = (count_r != '0);
  assign do_push = push && !full;
  assign do_pop  = deq && head_ok;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      snap_q[wr_ptr_r]  <= wr_snap;
      valid_q[wr_ptr_r] <= wr_valid;
      for (int k = 0; k < STRAGGLER_SLOTS; k++) begin
        dur_q[wr_ptr_r][k] <= wr_dur[k];
        end_q[wr_ptr_r][k] <= wr_end[k];
        src_q[wr_ptr_r][k] <= wr_src[k];
      end
    end
  end

  always_comb begin
    head_snap  = snap_q[rd_ptr_r];
    head_valid = valid_q[rd_ptr_r];
    for (int k = 0; k < STRAGGLER_SLOTS; k++) begin
      head_dur[k] = dur_q[rd_ptr_r][k];
      head_end[k] = end_q[rd_ptr_r][k];
      head_src[k] = src_q[rd_ptr_r][k];
    end
  end

endmodule

### sv/tbt_back.sv
// Back part: walks the ring slots of the oldest burst summary, keeps the
// running busy-time total and holds the result register. Uses tbt_pkg.
module tbt_back #(
  parameter int STRAGGLER_SLOTS = tbt_pkg::STRAGGLER_SLOTS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        head_ok,
  input  tbt_pkg::snap_t              head_snap,
  input  logic [STRAGGLER_SLOTS-1:0]  head_valid,
  input  logic [tbt_pkg::DUR_W-1:0]   head_dur [STRAGGLER_SLOTS],
  input  logic [tbt_pkg::TIME_W-1:0]  head_end [STRAGGLER_SLOTS],
  input  logic [tbt_pkg::SRC_W-1:0]   head_src [STRAGGLER_SLOTS],
  output logic                        deq,
  output logic                        out_empty,
  input  logic                        out_pop,
  output logic [tbt_pkg::TIME_W-1:0]  out_burst_start,
  output logic [tbt_pkg::TIME_W-1:0]  out_burst_end,
  output logic [tbt_pkg::CNT_W-1:0]   out_message_count,
  output logic [tbt_pkg::CNT_W-1:0]   out_max_overlap,
  output logic [tbt_pkg::BYTES_W-1:0] out_burst_bytes,
  output logic [tbt_pkg::BUSY_W-1:0]  out_total_busy_time,
  output logic                        out_straggler_valid,
  output logic [tbt_pkg::DUR_W-1:0]   out_straggler_duration,
  output logic [tbt_pkg::TIME_W-1:0]  out_straggler_end_time,
  output logic [tbt_pkg::SRC_W-1:0]   out_straggler_source,
  output logic                        out_count_underflow,
  output logic                        out_last
);

  localparam int SLOT_W = (STRAGGLER_SLOTS > 1) ? $clog2(STRAGGLER_SLOTS) : 1;

  logic                        out_valid_r;
  logic [SLOT_W-1:0]           slot_r;
  logic [tbt_pkg::BUSY_W-1:0]  busy_r;
  logic [tbt_pkg::BUSY_W:0]    busy_sum;
  logic [tbt_pkg::BUSY_W-1:0]  busy_nxt;
  logic                        load;
  logic                        slot_last;
  logic                        slot_ok;

  logic [tbt_pkg::TIME_W-1:0]  start_r, end_r, st_end_r;
  logic [tbt_pkg::CNT_W-1:0]   count_r, peak_r;
  logic [tbt_pkg::BYTES_W-1:0] bytes_r;
  logic [tbt_pkg::BUSY_W-1:0]  total_r;
  logic                        st_valid_r, underflow_r, last_r;
  logic [tbt_pkg::DUR_W-1:0]   st_dur_r;
  logic [tbt_pkg::SRC_W-1:0]   st_src_r;

  // The result register refills in the same cycle that it is drained.
  assign load      = head_ok && (!out_valid_r || (out_pop && out_valid_r));
  assign slot_last = (slot_r == SLOT_W'(STRAGGLER_SLOTS - 1));
  assign slot_ok   = head_valid[slot_r];
  assign deq       = load && slot_last;

  always_comb begin
    busy_sum = {1'b0, busy_r} + {{(tbt_pkg::BUSY_W+1-tbt_pkg::TIME_W){1'b0}}, head_snap.span};
    busy_nxt = busy_sum[tbt_pkg::BUSY_W] ? '1 : busy_sum[tbt_pkg::BUSY_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      slot_r      <= '0;
      busy_r      <= '0;
    end else if (load) begin
      out_valid_r <= 1'b1;
      slot_r      <= slot_last ? '0 : slot_r + 1'b1;
      if (slot_r == '0) begin
        busy_r <= busy_nxt;
      end
    end else if (out_pop) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      start_r     <= head_snap.burst_start;
      end_r       <= head_snap.burst_end;
      count_r     <= head_snap.message_count;
      peak_r      <= head_snap.max_overlap;
      bytes_r     <= head_snap.burst_bytes;
      total_r     <= (slot_r == '0) ? busy_nxt : busy_r;
      st_valid_r  <= slot_ok;
      st_dur_r    <= slot_ok ? head_dur[slot_r] : '0;
      st_end_r    <= slot_ok ? head_end[slot_r] : '0;
      st_src_r    <= slot_ok ? head_src[slot_r] : '0;
      underflow_r <= head_snap.underflow;
      last_r      <= slot_last;
    end
  end

  assign out_empty              = !out_valid_r;
  assign out_burst_start        = start_r;
  assign out_burst_end          = end_r;
  assign out_message_count      = count_r;
  assign out_max_overlap        = peak_r;
  assign out_burst_bytes        = bytes_r;
  assign out_total_busy_time    = total_r;
  assign out_straggler_valid    = st_valid_r;
  assign out_straggler_duration = st_dur_r;
  assign out_straggler_end_time = st_end_r;
  assign out_straggler_source   = st_src_r;
  assign out_count_underflow    = underflow_r;
  assign out_last               = last_r;

endmodule

### sv/traffic_burst_tracker.sv
// Top level of the traffic burst tracker: front part, summary queue, back part.
// Depends on tbt_pkg, tbt_front, tbt_queue, tbt_back and the assertion macro header.
//
// Usage:
//   Input requests are message start/end events, pushed with in_push while
//   in_full is low. Events must arrive in time order. A burst closes when an
//   event returns the active count to zero; that event produces one result
//   request per straggler slot (STRAGGLER_SLOTS of them, slot 0 first, out_last
//   on the final one). Results are read like a queue: a record is on the out_
//   ports while out_empty is low and is taken with out_pop.
// Timing:
//   Events that do not close a burst are taken one per cycle while in_full is
//   low. A closing event's summary is written to the summary queue and from there
//   is loaded into the result register. Records leave the single result register
//   at one per cycle while out_pop is high, one record per straggler slot.
//   The summary queue holds two closed bursts; in_full rises while it is full,
//   which happens only when the reader stalls or bursts close faster than
//   their records drain.
// Reset:
//   Synchronous, active low; clears all counts, the busy-time total, the ring
//   valid bits and the queue. No clearing pass is needed.
`include "traffic_burst_tracker_macros.svh"

module traffic_burst_tracker #(
  parameter int STRAGGLER_SLOTS = tbt_pkg::STRAGGLER_SLOTS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_push,
  output logic                              in_full,
  input  logic [tbt_pkg::TIME_W-1:0]        in_event_time,
  input  logic signed [tbt_pkg::MD_W-1:0]   in_message_delta,
  input  logic signed [tbt_pkg::SIZE_W-1:0] in_size_delta,
  input  logic [tbt_pkg::DUR_W-1:0]         in_duration_ns,
  input  logic [tbt_pkg::SRC_W-1:0]         in_source_slice,
  output logic                              out_empty,
  input  logic                              out_pop,
  output logic [tbt_pkg::TIME_W-1:0]        out_burst_start,
  output logic [tbt_pkg::TIME_W-1:0]        out_burst_end,
  output logic [tbt_pkg::CNT_W-1:0]         out_message_count,
  output logic [tbt_pkg::CNT_W-1:0]         out_max_overlap,
  output logic [tbt_pkg::BYTES_W-1:0]       out_burst_bytes,
  output logic [tbt_pkg::BUSY_W-1:0]        out_total_busy_time,
  output logic                              out_straggler_valid,
  output logic [tbt_pkg::DUR_W-1:0]         out_straggler_duration,
  output logic [tbt_pkg::TIME_W-1:0]        out_straggler_end_time,
  output logic [tbt_pkg::SRC_W-1:0]         out_straggler_source,
  output logic                              out_count_underflow,
  output logic                              out_last
);

  logic                        q_push, q_full, q_deq, q_head_ok;
  tbt_pkg::snap_t              q_wr_snap, q_head_snap;
  logic [STRAGGLER_SLOTS-1:0]  q_wr_valid, q_head_valid;
  logic [tbt_pkg::DUR_W-1:0]   q_wr_dur [STRAGGLER_SLOTS];
  logic [tbt_pkg::TIME_W-1:0]  q_wr_end [STRAGGLER_SLOTS];
  logic [tbt_pkg::SRC_W-1:0]   q_wr_src [STRAGGLER_SLOTS];
  logic [tbt_pkg::DUR_W-1:0]   q_head_dur [STRAGGLER_SLOTS];
  logic [tbt_pkg::TIME_W-1:0]  q_head_end [STRAGGLER_SLOTS];
  logic [tbt_pkg::SRC_W-1:0]   q_head_src [STRAGGLER_SLOTS];

  tbt_front #(.STRAGGLER_SLOTS(STRAGGLER_SLOTS)) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_push          (in_push),
    .in_full          (in_full),
    .in_event_time    (in_event_time),
    .in_message_delta (in_message_delta),
    .in_size_delta    (in_size_delta),
    .in_duration_ns   (in_duration_ns),
    .in_source_slice  (in_source_slice),
    .q_full           (q_full),
    .q_push           (q_push),
    .q_snap           (q_wr_snap),
    .q_ring_valid     (q_wr_valid),
    .q_ring_dur       (q_wr_dur),
    .q_ring_end       (q_wr_end),
    .q_ring_src       (q_wr_src)
  );

  tbt_queue #(.STRAGGLER_SLOTS(STRAGGLER_SLOTS)) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .full       (q_full),
    .wr_snap    (q_wr_snap),
    .wr_valid   (q_wr_valid),
    .wr_dur     (q_wr_dur),
    .wr_end     (q_wr_end),
    .wr_src     (q_wr_src),
    .deq        (q_deq),
    .head_ok    (q_head_ok),
    .head_snap  (q_head_snap),
    .head_valid (q_head_valid),
    .head_dur   (q_head_dur),
    .head_end   (q_head_end),
    .head_src   (q_head_src)
  );

  tbt_back #(.STRAGGLER_SLOTS(STRAGGLER_SLOTS)) u_back (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .head_ok                (q_head_ok),
    .head_snap              (q_head_snap),
    .head_valid             (q_head_valid),
    .head_dur               (q_head_dur),
    .head_end               (q_head_end),
    .head_src               (q_head_src),
    .deq                    (q_deq),
    .out_empty              (out_empty),
    .out_pop                (out_pop),
    .out_burst_start        (out_burst_start),
    .out_burst_end          (out_burst_end),
    .out_message_count      (out_message_count),
    .out_max_overlap        (out_max_overlap),
    .out_burst_bytes        (out_burst_bytes),
    .out_total_busy_time    (out_total_busy_time),
    .out_straggler_valid    (out_straggler_valid),
    .out_straggler_duration (out_straggler_duration),
    .out_straggler_end_time (out_straggler_end_time),
    .out_straggler_source   (out_straggler_source),
    .out_count_underflow    (out_count_underflow),
    .out_last               (out_last)
  );

  // A summary is only pushed when the queue has room for it.
  `TBT_ASSERT_IMP(a_push_not_full, clk, rst_n, q_push, !q_full)
  // The records of one burst follow each other without a gap.
  `TBT_ASSERT_NXT(a_burst_contiguous, clk, rst_n, out_pop && !out_empty && !out_last, !out_empty)
  // Reset leaves no result waiting.
  `TBT_ASSERT_RST(a_reset_empty, clk, !rst_n, out_empty)

endmodule

### sim/tb_traffic_burst_tracker.sv
`timescale 1ns / 100ps
// Self-checking testbench for traffic_burst_tracker: sends message start and end events,
// predicts every burst record with a local tracker and checks the records in order.
// Depends on tbt_pkg and the traffic_burst_tracker RTL.
module tb_traffic_burst_tracker;
  import tbt_pkg::*;

  localparam int SLOTS          = STRAGGLER_SLOTS_DEF;
  localparam int STALL_LIMIT    = 4000;
  localparam int RANDOM_EVENTS  = 280;
  localparam int TAIL_CYCLES    = 20;
  localparam int PRINT_LIMIT    = 100;

  // End codes of the message delta; a start is MD_START from the package.
  localparam logic signed [MD_W-1:0] MD_END_FLAT   = 2'sb00;
  localparam logic signed [MD_W-1:0] MD_END        = 2'sb11;
  localparam logic signed [MD_W-1:0] MD_END_DOUBLE = 2'sb10;

  localparam logic signed [SIZE_W-1:0] SIZE_TOP    = 33'sh0_FFFF_FFFF;
  localparam logic signed [SIZE_W-1:0] SIZE_BOTTOM = 33'sh1_0000_0000;
  localparam logic [TIME_W-1:0]        TIME_MAX    = '1;
  localparam logic [BYTES_W-1:0]       BYTES_MAX   = '1;
  localparam logic [CNT_W-1:0]         CNT_MAX     = '1;
  localparam longint                   LIVE_MAX    = 64'sd4294967295;
  localparam longint                   LIVE_MIN    = -64'sd4294967296;

  typedef struct {
    logic [TIME_W-1:0]        stamp;
    logic signed [MD_W-1:0]   delta;
    logic signed [SIZE_W-1:0] bytes;
    logic [DUR_W-1:0]         flight;
    logic [SRC_W-1:0]         slice;
  } traffic_event_t;

  typedef struct {
    logic [TIME_W-1:0]  burst_start;
    logic [TIME_W-1:0]  burst_end;
    logic [CNT_W-1:0]   message_count;
    logic [CNT_W-1:0]   max_overlap;
    logic [BYTES_W-1:0] burst_bytes;
    logic [BUSY_W-1:0]  total_busy_time;
    logic               straggler_valid;
    logic [DUR_W-1:0]   straggler_duration;
    logic [TIME_W-1:0]  straggler_end_time;
    logic [SRC_W-1:0]   straggler_source;
    logic               count_underflow;
    logic               last;
  } burst_record_t;

  logic                     clk;
  logic                     rst_n = 1'b0;
  logic                     in_push = 1'b0;
  logic                     in_full;
  logic [TIME_W-1:0]        in_event_time = '0;
  logic signed [MD_W-1:0]   in_message_delta = '0;
  logic signed [SIZE_W-1:0] in_size_delta = '0;
  logic [DUR_W-1:0]         in_duration_ns = '0;
  logic [SRC_W-1:0]         in_source_slice = '0;
  logic                     out_empty;
  logic                     out_pop = 1'b0;
  logic [TIME_W-1:0]        out_burst_start;
  logic [TIME_W-1:0]        out_burst_end;
  logic [CNT_W-1:0]         out_message_count;
  logic [CNT_W-1:0]         out_max_overlap;
  logic [BYTES_W-1:0]       out_burst_bytes;
  logic [BUSY_W-1:0]        out_total_busy_time;
  logic                     out_straggler_valid;
  logic [DUR_W-1:0]         out_straggler_duration;
  logic [TIME_W-1:0]        out_straggler_end_time;
  logic [SRC_W-1:0]         out_straggler_source;
  logic                     out_count_underflow;
  logic                     out_last;

  int send_gap_max   = 0;
  int pop_stall_max  = 0;
  int events_sent    = 0;
  int records_seen   = 0;
  int mismatches     = 0;
  int quiet_cycles   = 0;

  // Burst tracker state.
  longint             live_count;
  logic [TIME_W-1:0]  open_time;
  logic [CNT_W-1:0]   starts_in_burst;
  logic [CNT_W-1:0]   overlap_peak;
  logic [BYTES_W-1:0] bytes_in_burst;
  logic [BUSY_W-1:0]  busy_time;
  int                 ring_next;
  logic [DUR_W-1:0]   ring_flight [SLOTS];
  logic [TIME_W-1:0]  ring_stamp [SLOTS];
  logic [SRC_W-1:0]   ring_slice [SLOTS];
  logic [SLOTS-1:0]   ring_written;
  logic               went_negative;
  burst_record_t      expected_records[$];

  traffic_burst_tracker #(.STRAGGLER_SLOTS(SLOTS)) dut (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .in_push                (in_push),
    .in_full                (in_full),
    .in_event_time          (in_event_time),
    .in_message_delta       (in_message_delta),
    .in_size_delta          (in_size_delta),
    .in_duration_ns         (in_duration_ns),
    .in_source_slice        (in_source_slice),
    .out_empty              (out_empty),
    .out_pop                (out_pop),
    .out_burst_start        (out_burst_start),
    .out_burst_end          (out_burst_end),
    .out_message_count      (out_message_count),
    .out_max_overlap        (out_max_overlap),
    .out_burst_bytes        (out_burst_bytes),
    .out_total_busy_time    (out_total_busy_time),
    .out_straggler_valid    (out_straggler_valid),
    .out_straggler_duration (out_straggler_duration),
    .out_straggler_end_time (out_straggler_end_time),
    .out_straggler_source   (out_straggler_source),
    .out_count_underflow    (out_count_underflow),
    .out_last               (out_last)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic void clear_burst();
    live_count      = 0;
    ring_next       = 0;
    starts_in_burst = '0;
    overlap_peak    = '0;
    bytes_in_burst  = '0;
    went_negative   = 1'b0;
    ring_written    = '0;
  endfunction

  function automatic void clear_tracker();
    int k;
    clear_burst();
    open_time = '0;
    busy_time = '0;
    for (k = 0; k < SLOTS; k++) begin
      ring_flight[k] = '0;
      ring_stamp[k]  = '0;
      ring_slice[k]  = '0;
    end
  endfunction

  // Updates the tracker with one accepted event and queues the records of a
  // burst that it closes.
  function automatic void track_event(traffic_event_t ev);
    longint            bytes_next;
    logic [BUSY_W:0]   busy_next;
    logic [TIME_W-1:0] span;
    burst_record_t     rec;
    int                slot;
    int                k;
    if (live_count == 0) open_time = ev.stamp;
    live_count = live_count + longint'(ev.delta);
    if (live_count > LIVE_MAX) live_count = LIVE_MAX;
    if (live_count < LIVE_MIN) live_count = LIVE_MIN;
    if (live_count < 0) went_negative = 1'b1;
    if (ev.delta > 0) begin
      if (starts_in_burst != CNT_MAX) starts_in_burst = starts_in_burst + 1'b1;
      bytes_next = longint'(bytes_in_burst) + longint'(ev.bytes);
      if (bytes_next < 0) bytes_next = 0;
      if (bytes_next > longint'(BYTES_MAX)) bytes_next = longint'(BYTES_MAX);
      bytes_in_burst = bytes_next[BYTES_W-1:0];
    end else begin
      slot = ring_next;
      ring_flight[slot]  = ev.flight;
      ring_stamp[slot]   = ev.stamp;
      ring_slice[slot]   = ev.slice;
      ring_written[slot] = 1'b1;
      ring_next = (slot + 1) % SLOTS;
    end
    if (live_count > longint'(overlap_peak)) overlap_peak = live_count[CNT_W-1:0];
    if (live_count == 0) begin
      span = (ev.stamp >= open_time) ? ev.stamp - open_time : '0;
      busy_next = {1'b0, busy_time} + span;
      busy_time = busy_next[BUSY_W] ? '1 : busy_next[BUSY_W-1:0];
      for (k = 0; k < SLOTS; k++) begin
        rec.burst_start        = open_time;
        rec.burst_end          = ev.stamp;
        rec.message_count      = starts_in_burst;
        rec.max_overlap        = overlap_peak;
        rec.burst_bytes        = bytes_in_burst;
        rec.total_busy_time    = busy_time;
        rec.straggler_valid    = ring_written[k];
        rec.straggler_duration = ring_written[k] ? ring_flight[k] : '0;
        rec.straggler_end_time = ring_written[k] ? ring_stamp[k] : '0;
        rec.straggler_source   = ring_written[k] ? ring_slice[k] : '0;
        rec.count_underflow    = went_negative;
        rec.last               = (k == SLOTS - 1);
        expected_records.insert(expected_records.size(), rec);
      end
      clear_burst();
    end
  endfunction

  // The push line stays high after a request is taken so that a request with
  // no gap follows in the next cycle; anything that waits lowers it first.
  task automatic send_event(input logic [TIME_W-1:0] stamp, input logic signed [MD_W-1:0] delta,
                            input logic signed [SIZE_W-1:0] bytes,
                            input logic [DUR_W-1:0] flight, input logic [SRC_W-1:0] slice);
    traffic_event_t ev;
    int             gap;
    ev.stamp  = stamp;
    ev.delta  = delta;
    ev.bytes  = bytes;
    ev.flight = flight;
    ev.slice  = slice;
    gap = $urandom_range(0, send_gap_max);
    if (gap > 0) begin
      in_push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_push          <= 1'b1;
    in_event_time    <= ev.stamp;
    in_message_delta <= ev.delta;
    in_size_delta    <= ev.bytes;
    in_duration_ns   <= ev.flight;
    in_source_slice  <= ev.slice;
    @(posedge clk);
    while (in_full) @(posedge clk);
    track_event(ev);
    events_sent++;
  endtask

  task automatic wait_drained();
    in_push <= 1'b0;
    @(posedge clk);
    while (expected_records.size() != 0) @(posedge clk);
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    mismatches++;
    if (mismatches <= PRINT_LIMIT)
      $display("%0t ns: record %0d, %s: got 0x%0h, expected 0x%0h",
               $time, records_seen, what, got, want);
  endtask

  task automatic compare_field(input string what, input logic [63:0] got,
                               input logic [63:0] want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  initial begin : record_checker
    int            hold;
    burst_record_t want;
    hold = 0;
    forever begin
      @(posedge clk);
      if (out_pop && !out_empty) begin
        if (expected_records.size() == 0) begin
          report_mismatch("record with no closed burst", '0, '0);
        end else begin
          want = expected_records.pop_front();
          compare_field("burst_start", out_burst_start, want.burst_start);
          compare_field("burst_end", out_burst_end, want.burst_end);
          compare_field("message_count", out_message_count, want.message_count);
          compare_field("max_overlap", out_max_overlap, want.max_overlap);
          compare_field("burst_bytes", out_burst_bytes, want.burst_bytes);
          compare_field("total_busy_time", out_total_busy_time, want.total_busy_time);
          compare_field("straggler_valid", out_straggler_valid, want.straggler_valid);
          compare_field("straggler_duration", out_straggler_duration,
                        want.straggler_duration);
          compare_field("straggler_end_time", out_straggler_end_time,
                        want.straggler_end_time);
          compare_field("straggler_source", out_straggler_source, want.straggler_source);
          compare_field("count_underflow", out_count_underflow, want.count_underflow);
          compare_field("last", out_last, want.last);
        end
        records_seen++;
        hold = $urandom_range(0, pop_stall_max);
      end else if (hold > 0) begin
        hold--;
      end
      out_pop <= rst_n && (hold == 0);
    end
  end

  always @(posedge clk) begin
    if ((in_push && !in_full) || (out_pop && !out_empty)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin : watchdog
    wait (quiet_cycles >= STALL_LIMIT);
    $display("Regression FAIL");
    $finish;
  end

  function automatic logic signed [SIZE_W-1:0] random_bytes();
    case ($urandom_range(0, 7))
      0: return SIZE_W'({$urandom, $urandom});
      1: return -SIZE_W'($urandom_range(1, 4096));
      default: return SIZE_W'($urandom_range(1, 65535));
    endcase
  endfunction

  function automatic logic [DUR_W-1:0] random_flight();
    return DUR_W'({$urandom, $urandom});
  endfunction

  function automatic logic [SRC_W-1:0] random_slice();
    return SRC_W'($urandom);
  endfunction

  // Brings the active count back to zero so that the next burst starts clean.
  task automatic settle_count(inout logic [TIME_W-1:0] clock_ns);
    while (live_count != 0) begin
      clock_ns = clock_ns + TIME_W'($urandom_range(1, 20));
      if (live_count > 0)
        send_event(clock_ns, MD_END, random_bytes(), random_flight(), random_slice());
      else
        send_event(clock_ns, MD_START, random_bytes(), random_flight(), random_slice());
    end
  endtask

  task automatic send_random_burst(inout logic [TIME_W-1:0] clock_ns);
    int starts_left;
    int ends_left;
    int active;
    settle_count(clock_ns);
    starts_left = $urandom_range(1, 6);
    ends_left   = starts_left;
    active      = 0;
    while (starts_left + ends_left > 0) begin
      clock_ns = clock_ns + TIME_W'($urandom_range(0, 40));
      if ($urandom_range(0, 29) == 0) clock_ns = clock_ns - TIME_W'($urandom_range(1, 200));
      if (active > 0 && $urandom_range(0, 7) == 0) begin
        // An end with zero delta fills a ring slot but keeps the burst open.
        send_event(clock_ns, MD_END_FLAT, random_bytes(), random_flight(), random_slice());
      end else if (starts_left > 0 && (active == 0 || $urandom_range(0, 1) == 1)) begin
        send_event(clock_ns, MD_START, random_bytes(), random_flight(), random_slice());
        starts_left--;
        active++;
      end else if (active >= 2 && $urandom_range(0, 3) == 0) begin
        send_event(clock_ns, MD_END_DOUBLE, random_bytes(), random_flight(), random_slice());
        ends_left -= 2;
        active -= 2;
      end else begin
        send_event(clock_ns, MD_END, random_bytes(), random_flight(), random_slice());
        ends_left--;
        active--;
      end
    end
  endtask

  task automatic test_field_extremes();
    send_gap_max  = 0;
    pop_stall_max = 0;
    // A zero-delta end while idle opens and closes a burst by itself.
    send_event('0, MD_END_FLAT, '0, '0, '0);
    send_event(TIME_MAX, MD_END_FLAT, '1, '1, '1);
    // The second start takes the byte total below zero, where it holds at zero.
    send_event(TIME_W'(5), MD_START, SIZE_TOP, '0, '0);
    send_event(TIME_W'(6), MD_START, SIZE_BOTTOM, '1, '1);
    send_event(TIME_W'(7), MD_END_DOUBLE, '0, '1, SRC_W'(8'h5A));
  endtask

  task automatic test_overlap_and_bytes();
    send_gap_max  = 11;
    pop_stall_max = 11;
    send_event(TIME_W'(100), MD_START, SIZE_W'(1000), '0, SRC_W'(1));
    send_event(TIME_W'(110), MD_START, SIZE_W'(2000), '0, SRC_W'(2));
    send_event(TIME_W'(130), MD_START, SIZE_W'(5), '0, SRC_W'(3));
    send_event(TIME_W'(150), MD_END_DOUBLE, '0, DUR_W'(44), SRC_W'(4));
    send_event(TIME_W'(160), MD_END, '0, DUR_W'(55), SRC_W'(5));
  endtask

  task automatic test_ring_wrap();
    int k;
    send_gap_max  = 3;
    pop_stall_max = 0;
    send_event(TIME_W'(200), MD_START, SIZE_W'(64), '0, '0);
    // Five ends into four slots: the last one overwrites slot zero.
    for (k = 0; k < 4; k++)
      send_event(TIME_W'(210 + k), MD_END_FLAT, '0, DUR_W'(k + 1), SRC_W'(k + 16));
    send_event(TIME_W'(220), MD_END, '0, DUR_W'(99), SRC_W'(8'hC3));
  endtask

  task automatic test_count_underflow();
    send_gap_max  = 0;
    pop_stall_max = 11;
    // The count goes negative, and the burst it closes reports the underflow.
    send_event(TIME_W'(300), MD_END, '0, DUR_W'(7), SRC_W'(9));
    send_event(TIME_W'(301), MD_START, SIZE_W'(10), '0, '0);
    // The flag was cleared with those records.
    send_event(TIME_W'(310), MD_START, SIZE_W'(10), '0, '0);
    send_event(TIME_W'(311), MD_END, '0, DUR_W'(3), SRC_W'(2));
    // A double end while idle; the negative count must not raise the peak.
    send_event(TIME_W'(320), MD_END_DOUBLE, '0, DUR_W'(5), SRC_W'(6));
    send_event(TIME_W'(321), MD_START, SIZE_W'(1), '0, '0);
    send_event(TIME_W'(322), MD_START, SIZE_W'(1), '0, '0);
  endtask

  task automatic test_time_backwards();
    send_gap_max  = 11;
    pop_stall_max = 3;
    // The closing time is below the opening time, so no busy time is added.
    send_event(TIME_W'(1000), MD_START, SIZE_W'(8), '0, '0);
    send_event(TIME_W'(500), MD_END, '0, DUR_W'(12), SRC_W'(77));
  endtask

  task automatic test_random_traffic();
    logic [TIME_W-1:0] clock_ns;
    int                target;
    int                bursts;
    clock_ns = TIME_W'(2000);
    target   = events_sent + RANDOM_EVENTS;
    bursts   = 0;
    while (events_sent < target) begin
      // Each burst draws its own idling, so back-to-back runs occur as well.
      send_gap_max  = ($urandom_range(0, 3) == 0) ? 0 : 11;
      pop_stall_max = ($urandom_range(0, 3) == 0) ? 0 : 11;
      if (live_count == 0 && $urandom_range(0, 9) == 0) clock_ns = TIME_W'({$urandom, $urandom});
      if ($urandom_range(0, 4) == 0) begin
        send_event(clock_ns, MD_W'($urandom), SIZE_W'({$urandom, $urandom}), random_flight(),
                   random_slice());
      end else begin
        send_random_burst(clock_ns);
      end
      bursts++;
      if (bursts % 12 == 0) wait_drained();
    end
    settle_count(clock_ns);
    wait_drained();
  endtask

  task automatic test_busy_saturation();
    int k;
    send_gap_max  = 11;
    pop_stall_max = 11;
    // Each burst spans the whole time range; the running total hits its ceiling.
    for (k = 0; k < 4; k++) begin
      send_event('0, MD_START, SIZE_W'(k), '0, '0);
      send_event(TIME_MAX, MD_END, '0, random_flight(), random_slice());
    end
  endtask

  initial begin
    clear_tracker();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    test_field_extremes();
    test_overlap_and_bytes();
    test_ring_wrap();
    test_count_underflow();
    test_time_backwards();
    test_random_traffic();
    test_busy_saturation();
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_records.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
